>>> hw/rtl/spq_pkg.sv
`default_nettype none

package spq_pkg;

  // Queue geometry
  localparam int DEPTH = 16;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = $clog2(DEPTH + 1);
  localparam int SW    = AW + 2;

  // Field widths of the request and response
  localparam int KIND_W = 2;
  localparam int ID_W   = 16;
  localparam int CNT_W  = 16;
  localparam int POS_W  = 4;
  localparam int ST_W   = 3;
  localparam int LEN_W  = 5;

  typedef logic [AW-1:0] addr_t;
  typedef logic [CW-1:0] fill_t;

  // Operation codes
  typedef enum logic [KIND_W-1:0] {
    OP_INSERT = 2'd0,
    OP_POP    = 2'd1,
    OP_REMOVE = 2'd2,
    OP_FIND   = 2'd3
  } op_t;

  // Status codes
  localparam logic [ST_W-1:0] ST_OK        = 3'd0;
  localparam logic [ST_W-1:0] ST_EMPTY     = 3'd1;
  localparam logic [ST_W-1:0] ST_FULL      = 3'd2;
  localparam logic [ST_W-1:0] ST_NOT_FOUND = 3'd3;
  localparam logic [ST_W-1:0] ST_BAD_POS   = 3'd4;

  typedef struct packed {
    logic [ID_W-1:0]  id;
    logic [CNT_W-1:0] count;
  } entry_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [ID_W-1:0]   id;
    logic [CNT_W-1:0]  count;
    logic [POS_W-1:0]  position;
  } req_t;

  typedef struct packed {
    logic [ID_W-1:0]  id;
    logic [CNT_W-1:0] count;
    logic [POS_W-1:0] position;
    logic [ST_W-1:0]  status;
    logic [LEN_W-1:0] length;
  } rsp_t;

  typedef struct packed {
    logic   en;
    addr_t  addr;
    entry_t data;
  } mem_wr_t;

  typedef struct packed {
    logic  en;
    addr_t addr;
  } mem_rd_t;

  // Map a position from the head onto a slot of the circular store
  function automatic addr_t slot_of(addr_t head, fill_t pos);
    logic [SW-1:0] sum;
    sum = SW'(head) + SW'(pos);
    if (sum >= SW'(DEPTH)) begin
      sum = sum - SW'(DEPTH);
    end
    return AW'(sum);
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/spq_ifs.sv
`default_nettype none

// Request channel: operation and its operands
interface spq_req_if;
  import spq_pkg::*;
  logic                valid;
  logic                ready;
  logic [KIND_W-1:0]   kind;
  logic [ID_W-1:0]     in_id;
  logic [CNT_W-1:0]    in_count;
  logic [POS_W-1:0]    in_position;

  modport source (output valid, kind, in_id, in_count, in_position, input ready);
  modport sink   (input valid, kind, in_id, in_count, in_position, output ready);
endinterface

// Response channel: one result per request
interface spq_rsp_if;
  import spq_pkg::*;
  logic                valid;
  logic                ready;
  logic [ID_W-1:0]     out_id;
  logic [CNT_W-1:0]    out_count;
  logic [POS_W-1:0]    out_position;
  logic [ST_W-1:0]     status;
  logic [LEN_W-1:0]    length;

  modport source (output valid, out_id, out_count, out_position, status, length,
                  input ready);
  modport sink   (input valid, out_id, out_count, out_position, status, length,
                  output ready);
endinterface

`default_nettype wire

>>> hw/rtl/spq_store.sv
`default_nettype none

module spq_store (
  input  logic             clk,
  input  spq_pkg::mem_wr_t wr,
  input  spq_pkg::mem_rd_t rd,
  output spq_pkg::entry_t  rdata
);
  import spq_pkg::*;

  entry_t mem [DEPTH];
  entry_t rdata_r;

  // Write one slot, read one slot with registered data
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd.en) begin
      rdata_r <= mem[rd.addr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

>>> hw/rtl/spq_seq.sv
`default_nettype none

module spq_seq (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             req_valid,
  input  spq_pkg::req_t    req,
  output logic             req_ready,
  input  logic             slot_free,
  output logic             rsp_push,
  output spq_pkg::rsp_t    rsp,
  output spq_pkg::mem_wr_t mem_wr,
  output spq_pkg::mem_rd_t mem_rd,
  input  spq_pkg::entry_t  mem_rdata
);
  import spq_pkg::*;

  localparam int PW = (CW > POS_W) ? CW : POS_W;

  typedef enum logic [7:0] {
    S_IDLE     = 8'b0000_0001,
    S_INS_WALK = 8'b0000_0010,
    S_INS_PUT  = 8'b0000_0100,
    S_POP      = 8'b0000_1000,
    S_RM_FIRST = 8'b0001_0000,
    S_RM_WALK  = 8'b0010_0000,
    S_FIND     = 8'b0100_0000,
    S_DONE     = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;
  addr_t  head_r, head_nxt;
  fill_t  held_r, held_nxt;
  fill_t  k_r, k_nxt;
  req_t   req_r, req_nxt;
  rsp_t   res_r, res_nxt;

  logic [CW:0] kx;
  logic [CW:0] heldx;
  logic        pos_ge;
  entry_t      new_entry;

  assign kx        = {1'b0, k_r};
  assign heldx     = {1'b0, held_r};
  assign pos_ge    = PW'(req.position) >= PW'(held_r);
  assign new_entry = '{id: req_r.id, count: req_r.count};

  assign req_ready = (state_r == S_IDLE);
  assign rsp_push  = (state_r == S_DONE) && slot_free;

  // Length reflects the committed fill level
  always_comb begin
    rsp        = res_r;
    rsp.length = LEN_W'(held_r);
  end

  // Walk the store one slot per cycle; writes trail reads at other slots
  always_comb begin
    state_nxt = state_r;
    head_nxt  = head_r;
    held_nxt  = held_r;
    k_nxt     = k_r;
    req_nxt   = req_r;
    res_nxt   = res_r;
    mem_wr    = '0;
    mem_rd    = '0;

    case (state_r)
      S_IDLE: begin
        if (req_valid) begin
          req_nxt = req;
          res_nxt = '0;
          case (req.kind)
            OP_INSERT: begin
              if (held_r == CW'(DEPTH)) begin
                res_nxt.status = ST_FULL;
                state_nxt      = S_DONE;
              end else if (held_r == '0) begin
                mem_wr.en         = 1'b1;
                mem_wr.addr       = slot_of(head_r, '0);
                mem_wr.data.id    = req.id;
                mem_wr.data.count = req.count;
                held_nxt          = held_r + CW'(1);
                state_nxt         = S_DONE;
              end else begin
                mem_rd.en   = 1'b1;
                mem_rd.addr = slot_of(head_r, held_r - CW'(1));
                k_nxt       = held_r;
                state_nxt   = S_INS_WALK;
              end
            end
            OP_POP: begin
              if (held_r == '0) begin
                res_nxt.status = ST_EMPTY;
                state_nxt      = S_DONE;
              end else begin
                mem_rd.en   = 1'b1;
                mem_rd.addr = slot_of(head_r, '0);
                state_nxt   = S_POP;
              end
            end
            OP_REMOVE: begin
              if (held_r == '0) begin
                res_nxt.status = ST_EMPTY;
                state_nxt      = S_DONE;
              end else if (pos_ge) begin
                res_nxt.status = ST_BAD_POS;
                state_nxt      = S_DONE;
              end else begin
                mem_rd.en   = 1'b1;
                mem_rd.addr = slot_of(head_r, CW'(req.position));
                k_nxt       = CW'(req.position);
                state_nxt   = S_RM_FIRST;
              end
            end
            OP_FIND: begin
              if (held_r == '0) begin
                res_nxt.status = ST_EMPTY;
                state_nxt      = S_DONE;
              end else begin
                mem_rd.en   = 1'b1;
                mem_rd.addr = slot_of(head_r, '0);
                k_nxt       = '0;
                state_nxt   = S_FIND;
              end
            end
            default: begin
              state_nxt = S_DONE;
            end
          endcase
        end
      end

      // Read data is the entry at position k-1: place new entry or shift it down
      S_INS_WALK: begin
        mem_wr.en   = 1'b1;
        mem_wr.addr = slot_of(head_r, k_r);
        if (mem_rdata.count >= req_r.count) begin
          mem_wr.data = new_entry;
          held_nxt    = held_r + CW'(1);
          state_nxt   = S_DONE;
        end else begin
          mem_wr.data = mem_rdata;
          if (k_r == CW'(1)) begin
            k_nxt     = '0;
            state_nxt = S_INS_PUT;
          end else begin
            mem_rd.en   = 1'b1;
            mem_rd.addr = slot_of(head_r, k_r - CW'(2));
            k_nxt       = k_r - CW'(1);
          end
        end
      end

      S_INS_PUT: begin
        mem_wr.en   = 1'b1;
        mem_wr.addr = slot_of(head_r, k_r);
        mem_wr.data = new_entry;
        held_nxt    = held_r + CW'(1);
        state_nxt   = S_DONE;
      end

      S_POP: begin
        res_nxt.id    = mem_rdata.id;
        res_nxt.count = mem_rdata.count;
        head_nxt      = slot_of(head_r, CW'(1));
        held_nxt      = held_r - CW'(1);
        state_nxt     = S_DONE;
      end

      // Capture the removed entry, then close the gap behind it
      S_RM_FIRST: begin
        res_nxt.id    = mem_rdata.id;
        res_nxt.count = mem_rdata.count;
        if (kx + (CW+1)'(1) < heldx) begin
          mem_rd.en   = 1'b1;
          mem_rd.addr = slot_of(head_r, k_r + CW'(1));
          state_nxt   = S_RM_WALK;
        end else begin
          held_nxt  = held_r - CW'(1);
          state_nxt = S_DONE;
        end
      end

      S_RM_WALK: begin
        mem_wr.en   = 1'b1;
        mem_wr.addr = slot_of(head_r, k_r);
        mem_wr.data = mem_rdata;
        k_nxt       = k_r + CW'(1);
        if (kx + (CW+1)'(2) < heldx) begin
          mem_rd.en   = 1'b1;
          mem_rd.addr = slot_of(head_r, k_r + CW'(2));
        end else begin
          held_nxt  = held_r - CW'(1);
          state_nxt = S_DONE;
        end
      end

      // Compare one identifier per cycle from the head
      S_FIND: begin
        if (mem_rdata.id == req_r.id) begin
          res_nxt.position = POS_W'(k_r);
          state_nxt        = S_DONE;
        end else if (kx + (CW+1)'(1) < heldx) begin
          mem_rd.en   = 1'b1;
          mem_rd.addr = slot_of(head_r, k_r + CW'(1));
          k_nxt       = k_r + CW'(1);
        end else begin
          res_nxt.status = ST_NOT_FOUND;
          state_nxt      = S_DONE;
        end
      end

      // Hold the result until the output register frees up
      S_DONE: begin
        if (slot_free) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      head_r  <= '0;
      held_r  <= '0;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      held_r  <= held_nxt;
    end
  end

  always_ff @(posedge clk) begin
    k_r   <= k_nxt;
    req_r <= req_nxt;
    res_r <= res_nxt;
  end

  a_held_bound: assert property (@(posedge clk) disable iff (!rst_n)
    held_r <= CW'(DEPTH))
    else $error("fill level above depth");

  a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
    (mem_wr.en && mem_rd.en) |-> (mem_wr.addr != mem_rd.addr))
    else $error("read and write hit the same slot");

  a_full_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (req_ready && req_valid && req.kind == OP_INSERT && held_r == CW'(DEPTH))
    |=> (held_r == CW'(DEPTH) && state_r == S_DONE))
    else $error("insert into full queue changed state");

  a_push_idle: assert property (@(posedge clk) disable iff (!rst_n)
    rsp_push |=> req_ready)
    else $error("sequencer not idle after result");

endmodule

`default_nettype wire

>>> hw/rtl/sorted_priority_request_queue.sv
`default_nettype none
// Operations: pop reads the head slot only; insert, remove and find walk the
//   store port one slot per cycle.
// Throughput: one request at a time; a new request is taken once the prior
//   result sits in the output register, which frees the sequencer.
// Reset: synchronous, active low; clears head and fill level. Store contents
//   are not cleared, only filled slots are ever read.

module sorted_priority_request_queue (
  input  logic        clk,
  input  logic        rst_n,
  spq_req_if.sink     in_req,
  spq_rsp_if.source   out_rsp
);
  import spq_pkg::*;

  req_t    req;
  rsp_t    rsp;
  logic    rsp_push;
  logic    slot_free;
  mem_wr_t mem_wr;
  mem_rd_t mem_rd;
  entry_t  mem_rdata;

  logic    out_valid_r;
  rsp_t    out_rsp_r;

  assign req.kind     = in_req.kind;
  assign req.id       = in_req.in_id;
  assign req.count    = in_req.in_count;
  assign req.position = in_req.in_position;

  assign slot_free = !out_valid_r || out_rsp.ready;

  spq_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (in_req.valid),
    .req       (req),
    .req_ready (in_req.ready),
    .slot_free (slot_free),
    .rsp_push  (rsp_push),
    .rsp       (rsp),
    .mem_wr    (mem_wr),
    .mem_rd    (mem_rd),
    .mem_rdata (mem_rdata)
  );

  spq_store u_store (
    .clk   (clk),
    .wr    (mem_wr),
    .rd    (mem_rd),
    .rdata (mem_rdata)
  );

  // Load the output register on push, drop it when taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (rsp_push) begin
      out_valid_r <= 1'b1;
    end else if (out_rsp.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_push) begin
      out_rsp_r <= rsp;
    end
  end

  assign out_rsp.valid        = out_valid_r;
  assign out_rsp.out_id       = out_rsp_r.id;
  assign out_rsp.out_count    = out_rsp_r.count;
  assign out_rsp.out_position = out_rsp_r.position;
  assign out_rsp.status       = out_rsp_r.status;
  assign out_rsp.length       = out_rsp_r.length;

endmodule

`default_nettype wire

>>> tb/tb_sorted_priority_request_queue.sv
`timescale 1ns / 1ps

module tb_sorted_priority_request_queue;
  import spq_pkg::*;

  localparam int RANDOM_REQUESTS = 850;
  localparam int PHASE_LEN       = 50;
  localparam int DRAIN_CYCLES    = 40;
  localparam int REPORT_LIMIT    = 10;

  logic clk;
  logic rst_n;

  spq_req_if req_ch ();
  spq_rsp_if rsp_ch ();

  sorted_priority_request_queue dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (req_ch),
    .out_rsp (rsp_ch)
  );

  // Requests waiting to be driven, and results still owed by the block
  req_t   pending_requests[$];
  rsp_t   awaited_results[$];
  // Queue contents as the block should hold them, head first
  entry_t model_entries[$];
  // Same, as seen while the request list is being built
  entry_t plan_entries[$];

  int failures        = 0;
  int requests_sent   = 0;
  int results_checked = 0;
  int status_seen[5];

  int burst_left = 0;
  int gap_left   = 0;

  logic [15:0] ready_pattern = 16'hFFFF;
  logic [6:0]  ready_phase   = '0;

  // Apply one request to a queue image and return the result it yields
  function automatic rsp_t predict_queue_op(ref entry_t q[$], input req_t r);
    rsp_t   rsp;
    entry_t e;
    int     p;
    rsp        = '0;
    rsp.status = ST_OK;
    case (op_t'(r.kind))
      OP_INSERT: begin
        if (q.size() >= DEPTH) begin
          rsp.status = ST_FULL;
        end else begin
          // place behind every entry of equal or higher count
          p = 0;
          while (p < q.size() && q[p].count >= r.count) p++;
          e.id    = r.id;
          e.count = r.count;
          q.insert(p, e);
        end
      end
      OP_POP: begin
        if (q.size() == 0) begin
          rsp.status = ST_EMPTY;
        end else begin
          e         = q.pop_front();
          rsp.id    = e.id;
          rsp.count = e.count;
        end
      end
      OP_REMOVE: begin
        if (q.size() == 0) begin
          rsp.status = ST_EMPTY;
        end else if (int'(r.position) >= q.size()) begin
          rsp.status = ST_BAD_POS;
        end else begin
          e         = q[r.position];
          rsp.id    = e.id;
          rsp.count = e.count;
          q.delete(int'(r.position));
        end
      end
      default: begin
        if (q.size() == 0) begin
          rsp.status = ST_EMPTY;
        end else begin
          // report the match nearest the head
          rsp.status = ST_NOT_FOUND;
          for (p = 0; p < q.size(); p++) begin
            if (q[p].id == r.id) begin
              rsp.status   = ST_OK;
              rsp.position = POS_W'(p);
              break;
            end
          end
        end
      end
    endcase
    rsp.length = LEN_W'(q.size());
    return rsp;
  endfunction

  // Queue one request for the driver and track its effect on the plan
  task automatic add_request(op_t op, logic [ID_W-1:0] id, logic [CNT_W-1:0] cnt,
                             logic [POS_W-1:0] pos);
    req_t r;
    r.kind     = op;
    r.id       = id;
    r.count    = cnt;
    r.position = pos;
    pending_requests.push_back(r);
    void'(predict_queue_op(plan_entries, r));
  endtask

  // Build a random request; insert_pct sets how hard the phase fills the queue
  task automatic add_random_request(int insert_pct);
    op_t              op;
    logic [ID_W-1:0]  id;
    logic [CNT_W-1:0] cnt;
    logic [POS_W-1:0] pos;
    int               pick;
    pick = $urandom_range(0, 99);
    if (pick < insert_pct) begin
      op = OP_INSERT;
    end else begin
      case ($urandom_range(0, 2))
        0:       op = OP_POP;
        1:       op = OP_REMOVE;
        default: op = OP_FIND;
      endcase
    end
    // identifiers mostly from a small pool so that finds hit and repeat
    id = ($urandom_range(0, 9) < 7) ? ID_W'($urandom_range(0, 31)) : ID_W'($urandom);
    if (op == OP_FIND && plan_entries.size() > 0 && $urandom_range(0, 9) < 6) begin
      id = plan_entries[$urandom_range(0, plan_entries.size() - 1)].id;
    end
    // counts: many ties, some extremes, the rest spread over the range
    pick = $urandom_range(0, 9);
    if (pick < 4) begin
      cnt = CNT_W'($urandom_range(0, 7));
    end else if (pick == 4) begin
      cnt = $urandom_range(0, 1) ? '1 : '0;
    end else begin
      cnt = CNT_W'($urandom);
    end
    pos = POS_W'($urandom_range(0, 15));
    if (op == OP_REMOVE && plan_entries.size() > 0 && $urandom_range(0, 9) < 7) begin
      pos = POS_W'($urandom_range(0, plan_entries.size() - 1));
    end
    add_request(op, id, cnt, pos);
  endtask

  // Record one failed check, with detail for the first few
  task automatic report_mismatch(string what, rsp_t want, rsp_t got);
    failures++;
    if (failures <= REPORT_LIMIT) begin
      $display("%s at result %0d: expected id=%h count=%h pos=%0d status=%0d len=%0d",
               what, results_checked, want.id, want.count, want.position,
               want.status, want.length);
      $display("    got id=%h count=%h pos=%0d status=%0d len=%0d",
               got.id, got.count, got.position, got.status, got.length);
    end
  endtask

  // Clock, reset and known input levels from time zero
  initial begin
    clk                 = 1'b0;
    rst_n               = 1'b0;
    req_ch.valid        = 1'b0;
    req_ch.kind         = '0;
    req_ch.in_id        = '0;
    req_ch.in_count     = '0;
    req_ch.in_position  = '0;
    rsp_ch.ready        = 1'b0;
    fork
      forever #5 clk = ~clk;
      begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
      end
    join_none
  end

  // Drive requests in bursts with random gaps
  always @(posedge clk) begin : drive_requests
    req_t seen;
    req_t nxt;
    if (!rst_n) begin
      req_ch.valid <= 1'b0;
    end else begin
      // predict the request taken at this edge
      if (req_ch.valid && req_ch.ready) begin
        seen.kind     = req_ch.kind;
        seen.id       = req_ch.in_id;
        seen.count    = req_ch.in_count;
        seen.position = req_ch.in_position;
        awaited_results.push_back(predict_queue_op(model_entries, seen));
        requests_sent++;
      end
      // advance to the next request unless one is held
      if (!req_ch.valid || req_ch.ready) begin
        if (burst_left == 0) begin
          if (gap_left > 0) begin
            gap_left--;
          end else begin
            burst_left = $urandom_range(1, 24);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
          end
        end
        if (burst_left > 0 && pending_requests.size() > 0) begin
          nxt = pending_requests.pop_front();
          burst_left--;
          req_ch.valid       <= 1'b1;
          req_ch.kind        <= nxt.kind;
          req_ch.in_id       <= nxt.id;
          req_ch.in_count    <= nxt.count;
          req_ch.in_position <= nxt.position;
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Check results and stall the response channel on a rotating pattern
  always @(posedge clk) begin : check_results
    rsp_t got;
    rsp_t want;
    if (!rst_n) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        got.id       = rsp_ch.out_id;
        got.count    = rsp_ch.out_count;
        got.position = rsp_ch.out_position;
        got.status   = rsp_ch.status;
        got.length   = rsp_ch.length;
        if (awaited_results.size() == 0) begin
          report_mismatch("unexpected result", '0, got);
        end else begin
          want = awaited_results.pop_front();
          if (got.id !== want.id || got.count !== want.count ||
              got.position !== want.position || got.status !== want.status ||
              got.length !== want.length) begin
            report_mismatch("mismatch", want, got);
          end
          if (want.status <= ST_BAD_POS) status_seen[want.status]++;
        end
        results_checked++;
      end
      // reload the stall pattern now and then, sometimes with no stalls at all
      if (ready_phase == '1) begin
        case ($urandom_range(0, 3))
          0:       ready_pattern <= 16'hFFFF;
          1:       ready_pattern <= 16'($urandom & $urandom) | 16'h0001;
          default: ready_pattern <= 16'($urandom) | 16'h0001;
        endcase
      end
      rsp_ch.ready <= ready_pattern[ready_phase[3:0]];
      ready_phase  <= ready_phase + 7'd1;
    end
  end

  // Build the request list, then wait for the queue to drain
  initial begin : run_requests
    int phase_pct;
    // empty queue cases
    add_request(OP_POP, '0, '0, '0);
    add_request(OP_REMOVE, '0, '0, '0);
    add_request(OP_FIND, '1, '0, '0);
    // fill to the limit: extremes, ties, a repeated identifier
    add_request(OP_INSERT, '1, '1, '0);
    add_request(OP_INSERT, '0, '0, '1);
    add_request(OP_INSERT, 16'd1, 16'd100, '0);
    add_request(OP_INSERT, 16'd2, 16'd100, '0);
    add_request(OP_INSERT, 16'd3, 16'd100, '0);
    add_request(OP_INSERT, 16'd1, 16'd200, '0);
    add_request(OP_INSERT, 16'hAAAA, 16'h5555, '0);
    add_request(OP_INSERT, 16'h5555, 16'hAAAA, '0);
    for (int i = 0; i < 8; i++) begin
      add_request(OP_INSERT, ID_W'(16 + i), CNT_W'(i * 7), '0);
    end
    // insert into a full queue is dropped
    add_request(OP_INSERT, 16'd7, '1, '0);
    // repeated identifier reports the one nearest the head; then a miss
    add_request(OP_FIND, 16'd1, '0, '0);
    add_request(OP_FIND, 16'h1234, '0, '0);
    // remove the tail, then the same position once it is out of range
    add_request(OP_REMOVE, '0, '0, 4'd15);
    add_request(OP_REMOVE, '0, '0, 4'd15);
    add_request(OP_POP, '0, '0, '0);

    // random phases alternate between filling, steady and draining
    phase_pct = 50;
    for (int i = 0; i < RANDOM_REQUESTS; i++) begin
      if (i % PHASE_LEN == 0) begin
        case ($urandom_range(0, 2))
          0:       phase_pct = 75;
          1:       phase_pct = 50;
          default: phase_pct = 25;
        endcase
      end
      add_random_request(phase_pct);
    end

    @(posedge clk);
    while (!rst_n || pending_requests.size() != 0 || req_ch.valid ||
           awaited_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("requests sent %0d, results checked %0d, mismatches %0d",
             requests_sent, results_checked, failures);
    $display("status ok %0d, empty %0d, full %0d, not found %0d, bad position %0d",
             status_seen[ST_OK], status_seen[ST_EMPTY], status_seen[ST_FULL],
             status_seen[ST_NOT_FOUND], status_seen[ST_BAD_POS]);
    if (failures == 0 && awaited_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Stop a hung run
  initial begin : watchdog
    #5_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule
